// File: rtl/core/battery_level_interpolator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the battery level interpolator
// Clocked on clk; one form is gated by reset, the other checks through reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_INTERPOLATOR_UNIT_ASSERT_SVH
`define BATTERY_LEVEL_INTERPOLATOR_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define BLI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("battery level interpolator assertion failed");

// Checked at every edge, reset included.
`define BLI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("battery level interpolator assertion failed");

`endif

// File: rtl/core/bli_pkg.sv
// ----------------------------------------------------------------------------
// bli_pkg
// Widths, register map and reset values of the battery level interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bli_pkg;

  localparam int MV_W    = 16;
  localparam int LEVEL_W = 14;
  localparam int PROD_W  = MV_W + LEVEL_W;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_TOP_MV = 3'd0;
  localparam logic [2:0] REG_TOP_LVL = 3'd1;
  localparam logic [2:0] REG_MID_MV = 3'd2;
  localparam logic [2:0] REG_MID_LVL = 3'd3;
  localparam logic [2:0] REG_BOT_MV = 3'd4;
  localparam logic [2:0] REG_BOT_LVL = 3'd5;

  localparam logic [MV_W-1:0]    RST_TOP_MV  = 16'd3950;
  localparam logic [LEVEL_W-1:0] RST_TOP_LVL = 14'd10000;
  localparam logic [MV_W-1:0]    RST_MID_MV  = 16'd3550;
  localparam logic [LEVEL_W-1:0] RST_MID_LVL = 14'd625;
  localparam logic [MV_W-1:0]    RST_BOT_MV  = 16'd3100;
  localparam logic [LEVEL_W-1:0] RST_BOT_LVL = 14'd0;

endpackage

`default_nettype wire

// File: rtl/core/battery_level_interpolator_unit.sv
// ----------------------------------------------------------------------------
// battery_level_interpolator_unit
// Outside the curve, an input transaction goes from the segment choice straight
// to the output register; inside it, a shift-add multiply runs, then a
// restoring divide, one quotient bit per cycle. One item at a time: the next
// input is taken only once the last result is registered, later if a result stalls.
// Synchronous active-low reset restores the curve registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_interpolator_unit
  import bli_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,    // [15:0] millivolts
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,   // [13:0] charge_level, [15:14] zero
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEL  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [3:0] MUL_LAST = 4'(MV_W - 1);
  localparam logic [3:0] DIV_LAST = 4'(LEVEL_W - 1);

  // curve registers
  logic [MV_W-1:0]    top_mv_r, mid_mv_r, bot_mv_r;
  logic [LEVEL_W-1:0] top_lvl_r, mid_lvl_r, bot_lvl_r;
  logic [2:0]         cfg_idx;
  logic               cfg_wr;

  // datapath
  logic [2:0]         state_r, state_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [MV_W-1:0]    mv_r, mv_nxt;
  logic [MV_W-1:0]    span_r, span_nxt;
  logic [LEVEL_W-1:0] rise_r, rise_nxt;
  logic [LEVEL_W-1:0] base_r, base_nxt;
  logic               neg_r, neg_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_data_r, out_data_nxt;

  // segment selection
  logic               ge_top, ge_mid, ge_bot, seg_hi;
  logic [MV_W-1:0]    hi_mv, lo_mv;
  logic [LEVEL_W-1:0] hi_lvl, lo_lvl;

  // serial arithmetic
  logic [LEVEL_W:0]   mul_sum;
  logic [MV_W:0]      div_trial;
  logic [MV_W:0]      div_diff;
  logic [LEVEL_W-1:0] result;
  logic               out_free;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_mv_r  <= RST_TOP_MV;
      top_lvl_r <= RST_TOP_LVL;
      mid_mv_r  <= RST_MID_MV;
      mid_lvl_r <= RST_MID_LVL;
      bot_mv_r  <= RST_BOT_MV;
      bot_lvl_r <= RST_BOT_LVL;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TOP_MV:  top_mv_r  <= cfg_pwdata[MV_W-1:0];
        REG_TOP_LVL: top_lvl_r <= cfg_pwdata[LEVEL_W-1:0];
        REG_MID_MV:  mid_mv_r  <= cfg_pwdata[MV_W-1:0];
        REG_MID_LVL: mid_lvl_r <= cfg_pwdata[LEVEL_W-1:0];
        REG_BOT_MV:  bot_mv_r  <= cfg_pwdata[MV_W-1:0];
        REG_BOT_LVL: bot_lvl_r <= cfg_pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TOP_MV:  cfg_prdata = DATA_W'(top_mv_r);
      REG_TOP_LVL: cfg_prdata = DATA_W'(top_lvl_r);
      REG_MID_MV:  cfg_prdata = DATA_W'(mid_mv_r);
      REG_MID_LVL: cfg_prdata = DATA_W'(mid_lvl_r);
      REG_BOT_MV:  cfg_prdata = DATA_W'(bot_mv_r);
      REG_BOT_LVL: cfg_prdata = DATA_W'(bot_lvl_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // segment choice: the upper segment runs mid..top, the lower bottom..mid
  // --------------------------------------------------------------------------
  assign ge_top = (mv_r >= top_mv_r);
  assign ge_mid = (mv_r >= mid_mv_r);
  assign ge_bot = (mv_r >= bot_mv_r);
  assign seg_hi = ge_mid;

  assign hi_mv  = seg_hi ? top_mv_r  : mid_mv_r;
  assign lo_mv  = seg_hi ? mid_mv_r  : bot_mv_r;
  assign hi_lvl = seg_hi ? top_lvl_r : mid_lvl_r;
  assign lo_lvl = seg_hi ? mid_lvl_r : bot_lvl_r;

  // LSB-first shift-add: high half accumulates, multiplier shifts out below
  assign mul_sum = {1'b0, prod_r[PROD_W-1:MV_W]} +
                   (prod_r[0] ? {1'b0, rise_r} : '0);

  // restoring divide: partial remainder in the high bits, quotient shifts in
  assign div_trial = {prod_r[PROD_W-1:LEVEL_W], prod_r[LEVEL_W-1]};
  assign div_diff  = div_trial - {1'b0, span_r};

  // quotient magnitude is below the level rise, so the result stays in range
  assign result   = neg_r ? (base_r - prod_r[LEVEL_W-1:0])
                          : (base_r + prod_r[LEVEL_W-1:0]);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mv_nxt        = mv_r;
    span_nxt      = span_r;
    rise_nxt      = rise_r;
    base_nxt      = base_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mv_nxt    = in_tdata;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (ge_top || (!ge_mid && !ge_bot)) begin
          // outside the curve: pass the end level straight through
          base_nxt  = ge_top ? top_lvl_r : bot_lvl_r;
          neg_nxt   = 1'b0;
          prod_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          span_nxt  = hi_mv - lo_mv;
          neg_nxt   = (hi_lvl < lo_lvl);
          rise_nxt  = (hi_lvl < lo_lvl) ? (lo_lvl - hi_lvl) : (hi_lvl - lo_lvl);
          base_nxt  = lo_lvl;
          prod_nxt  = {{LEVEL_W{1'b0}}, mv_r - lo_mv};
          cnt_nxt   = MUL_LAST;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt = {mul_sum, prod_r[MV_W-1:1]};
        cnt_nxt  = cnt_r - 4'd1;
        if (cnt_r == '0) begin
          cnt_nxt   = DIV_LAST;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_diff[MV_W]) begin
          prod_nxt = {div_diff[MV_W-1:0], prod_r[LEVEL_W-2:0], 1'b1};
        end else begin
          prod_nxt = {div_trial[MV_W-1:0], prod_r[LEVEL_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_data_nxt  = result;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mv_r       <= mv_nxt;
    span_r     <= span_nxt;
    rise_r     <= rise_nxt;
    base_r     <= base_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

endmodule

`default_nettype wire

// File: rtl/core/bli_checker.sv
// ----------------------------------------------------------------------------
// bli_checker
// Port-level checks on the battery level interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_level_interpolator_unit_assert.svh"

module bli_checker
  import bli_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // a stalled result keeps its value
  `BLI_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // padding above the level field is always zero
  `BLI_ASSERT_ALWAYS(a_out_pad, out_tdata[15:LEVEL_W] == '0)

  // an accepted transaction makes the input side busy in the next cycle
  `BLI_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready)

  // a new result only appears while the input side was already busy just before
  `BLI_ASSERT(a_result_from_busy, $rose(out_tvalid) |-> $past(!in_tready))

endmodule

bind battery_level_interpolator_unit bli_checker u_bli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: bench/battery_level_interpolator_unit_tb.sv
// ----------------------------------------------------------------------------
// battery_level_interpolator_unit_tb
// Streams voltages through the interpolator under a series of discharge
// curves (default, realistic, arbitrary, flat, non-descending, extreme) and
// checks every charge level against a local piecewise-linear predictor.
// ----------------------------------------------------------------------------

module battery_level_interpolator_unit_tb;
  import bli_pkg::*;

  localparam int          RANDOM_ITEMS = 1300;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 1000000;
  // addresses past the register map; writes there must be dropped
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;

  // Holds the curve copy and the levels still owed by the block.
  class level_scoreboard;
    logic [MV_W-1:0]    top_mv, mid_mv, bot_mv;
    logic [LEVEL_W-1:0] top_lvl, mid_lvl, bot_lvl;
    logic [LEVEL_W-1:0] owed_levels[$];
    int unsigned        errors;
    int unsigned        voltages_seen;
    int unsigned        levels_checked;

    function new();
      top_mv  = RST_TOP_MV;
      top_lvl = RST_TOP_LVL;
      mid_mv  = RST_MID_MV;
      mid_lvl = RST_MID_LVL;
      bot_mv  = RST_BOT_MV;
      bot_lvl = RST_BOT_LVL;
      errors = 0;
      voltages_seen = 0;
      levels_checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_TOP_MV:  top_mv  = value[MV_W-1:0];
        REG_TOP_LVL: top_lvl = value[LEVEL_W-1:0];
        REG_MID_MV:  mid_mv  = value[MV_W-1:0];
        REG_MID_LVL: mid_lvl = value[LEVEL_W-1:0];
        REG_BOT_MV:  bot_mv  = value[MV_W-1:0];
        REG_BOT_LVL: bot_lvl = value[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [LEVEL_W-1:0] segment_level(logic [MV_W-1:0] mv, hi_mv,
                                               logic [LEVEL_W-1:0] hi_lvl,
                                               logic [MV_W-1:0] lo_mv,
                                               logic [LEVEL_W-1:0] lo_lvl);
      longint span, rise, offs, res;
      span = longint'(hi_mv) - longint'(lo_mv);
      if (span == 0) return lo_lvl;
      rise = longint'(hi_lvl) - longint'(lo_lvl);
      offs = longint'(mv) - longint'(lo_mv);
      // signed divide, truncates toward zero
      res = longint'(lo_lvl) + (rise * offs) / span;
      if (res < 0) res = 0;
      return res[LEVEL_W-1:0];
    endfunction

    function logic [LEVEL_W-1:0] interpolate(logic [MV_W-1:0] mv);
      if (mv >= top_mv) return top_lvl;
      if (mv >= mid_mv) return segment_level(mv, top_mv, top_lvl, mid_mv, mid_lvl);
      if (mv >= bot_mv) return segment_level(mv, mid_mv, mid_lvl, bot_mv, bot_lvl);
      return bot_lvl;
    endfunction

    function void note_voltage(logic [15:0] data);
      owed_levels.push_back(interpolate(data[MV_W-1:0]));
      voltages_seen++;
    endfunction

    function void check_level(logic [15:0] data);
      logic [LEVEL_W-1:0] expected_level;
      if (owed_levels.size() == 0) begin
        $error("charge_level: no level expected, actual %0d", data[LEVEL_W-1:0]);
        errors++;
        return;
      end
      expected_level = owed_levels.pop_front();
      levels_checked++;
      if (data[LEVEL_W-1:0] !== expected_level) begin
        $error("charge_level: expected %0d, actual %0d", expected_level,
               data[LEVEL_W-1:0]);
        errors++;
      end
    endfunction

    function int pending();
      return owed_levels.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;    // [15:0] millivolts
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;   // [13:0] charge_level, [15:14] zero
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  level_scoreboard levels_sb = new();
  bit              hold_request;
  int unsigned     holds_done;
  int unsigned     curves_loaded;
  int unsigned     cycle_count;

  battery_level_interpolator_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d levels owed", cycle_count,
             levels_sb.pending());
    $display("Regression FAIL");
    $finish;
  end

  // transaction monitors, sampled at the edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) levels_sb.note_voltage(in_tdata);
    if (rst_n && out_tvalid && out_tready) levels_sb.check_level(out_tdata);
  end

  // result side: random stall spans, plus one long hold-off on request
  initial begin : receiver
    int unsigned span_len;
    int unsigned stall_pct;
    holds_done = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        holds_done++;
      end else begin
        span_len = $urandom_range(80, 4);
        case ($urandom_range(3, 0))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        repeat (span_len) begin
          out_tready <= ($urandom_range(99, 0) >= stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    levels_sb.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // sometimes sets bits above the field; the block must drop them
  function automatic logic [31:0] with_junk(logic [31:0] field, int width);
    if ($urandom_range(3, 0) != 0) return field;
    return field | ($urandom << width);
  endfunction

  task automatic load_curve(input int tm, tl, mm, ml, bm, bl);
    cfg_write(REG_TOP_MV,  with_junk(tm, MV_W));
    cfg_write(REG_TOP_LVL, with_junk(tl, LEVEL_W));
    cfg_write(REG_MID_MV,  with_junk(mm, MV_W));
    cfg_write(REG_MID_LVL, with_junk(ml, LEVEL_W));
    cfg_write(REG_BOT_MV,  with_junk(bm, MV_W));
    cfg_write(REG_BOT_LVL, with_junk(bl, LEVEL_W));
    curves_loaded++;
  endtask

  task automatic load_random_curve();
    int tm, mm, bm, tl, ml, bl, swap_tmp, v;
    case ($urandom_range(4, 0))
      0: begin  // realistic discharge curve
        bm = $urandom_range(3300, 2800);
        mm = bm + $urandom_range(600, 100);
        tm = mm + $urandom_range(700, 100);
        bl = $urandom_range(500, 0);
        ml = $urandom_range(5000, bl);
        tl = $urandom_range(10000, ml);
      end
      1: begin  // descending over the full range
        tm = $urandom_range(65535, 0);
        mm = $urandom_range(65535, 0);
        bm = $urandom_range(65535, 0);
        if (tm < mm) begin swap_tmp = tm; tm = mm; mm = swap_tmp; end
        if (mm < bm) begin swap_tmp = mm; mm = bm; bm = swap_tmp; end
        if (tm < mm) begin swap_tmp = tm; tm = mm; mm = swap_tmp; end
        tl = $urandom_range(10000, 0);
        ml = $urandom_range(10000, 0);
        bl = $urandom_range(10000, 0);
      end
      2: begin  // anything, order and levels unchecked
        tm = $urandom_range(65535, 0);
        mm = $urandom_range(65535, 0);
        bm = $urandom_range(65535, 0);
        tl = $urandom_range(16383, 0);
        ml = $urandom_range(16383, 0);
        bl = $urandom_range(16383, 0);
      end
      3: begin  // flat spots: coinciding voltages
        v  = $urandom_range(65535, 2000);
        tm = v;
        mm = $urandom_range(1, 0) ? v : v - $urandom_range(2000, 1);
        bm = (mm == v) ? v - $urandom_range(2000, 0) : mm;
        tl = $urandom_range(16383, 0);
        ml = $urandom_range(16383, 0);
        bl = $urandom_range(16383, 0);
      end
      default: begin  // corner values only
        tm = ($urandom_range(2, 0) == 0) ? 0 : ($urandom_range(1, 0) ? 65535 : 32768);
        mm = ($urandom_range(2, 0) == 0) ? 0 : ($urandom_range(1, 0) ? 65535 : 32768);
        bm = ($urandom_range(2, 0) == 0) ? 0 : ($urandom_range(1, 0) ? 65535 : 32768);
        tl = ($urandom_range(2, 0) == 0) ? 0 : ($urandom_range(1, 0) ? 16383 : 10000);
        ml = ($urandom_range(2, 0) == 0) ? 0 : ($urandom_range(1, 0) ? 16383 : 10000);
        bl = ($urandom_range(2, 0) == 0) ? 0 : ($urandom_range(1, 0) ? 16383 : 10000);
      end
    endcase
    load_curve(tm, tl, mm, ml, bm, bl);
    if ($urandom_range(3, 0) == 0)
      cfg_write($urandom_range(1, 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
  endtask

  // voltages biased toward the curve and its breakpoints
  function automatic logic [15:0] pick_voltage();
    int r, knee, lo, hi;
    r = $urandom_range(99, 0);
    if (r < 15) return 16'($urandom);
    if (r < 22) return $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
    if (r < 45) begin
      case ($urandom_range(2, 0))
        0: knee = levels_sb.top_mv;
        1: knee = levels_sb.mid_mv;
        default: knee = levels_sb.bot_mv;
      endcase
      knee = knee + $urandom_range(2, 0) - 1;
      if (knee < 0) knee = 0;
      if (knee > 65535) knee = 65535;
      return knee[15:0];
    end
    lo = levels_sb.bot_mv;
    hi = levels_sb.bot_mv;
    if (levels_sb.top_mv < lo) lo = levels_sb.top_mv;
    if (levels_sb.mid_mv < lo) lo = levels_sb.mid_mv;
    if (levels_sb.top_mv > hi) hi = levels_sb.top_mv;
    if (levels_sb.mid_mv > hi) hi = levels_sb.mid_mv;
    lo = (lo < 40) ? 0 : lo - 40;
    hi = (hi > 65495) ? 65535 : hi + 40;
    return 16'($urandom_range(hi, lo));
  endfunction

  task automatic offer_voltage(input logic [15:0] mv);
    in_tvalid <= 1'b1;
    in_tdata  <= mv;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (levels_sb.pending() != 0) @(posedge clk);
  endtask

  // idle point for register writes: nothing in flight
  task automatic settle();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] default_points[$];
    logic [15:0] flat_points[$];
    logic [15:0] corner_points[$];
    int unsigned random_sent;
    int unsigned phase_items;
    int unsigned phase_sent;
    int unsigned burst_len;
    int unsigned gap;

    default_points = '{16'd0, 16'd3099, 16'd3100, 16'd3101, 16'd3325, 16'd3549,
                       16'd3550, 16'd3551, 16'd3750, 16'd3949, 16'd3950, 16'hFFFF};
    flat_points    = '{16'd2999, 16'd3000, 16'd1000, 16'd999, 16'd2000};
    corner_points  = '{16'hFFFF, 16'hFFFE, 16'h0000, 16'h5555, 16'hAAAA};
    hold_request   = 1'b0;
    curves_loaded  = 0;
    random_sent    = 0;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset curve, all three breakpoints and the ends of the range
    foreach (default_points[i]) offer_voltage(default_points[i]);
    settle();

    // unmapped writes, then a curve with a zero-span top segment and
    // levels above full scale
    cfg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_HI, 32'h0000_0000);
    load_curve(3000, 16383, 3000, 12000, 1000, 10001);
    foreach (flat_points[i]) offer_voltage(flat_points[i]);
    settle();

    // non-descending curve at the register extremes
    load_curve(65535, 0, 0, 16383, 65535, 5000);
    foreach (corner_points[i]) offer_voltage(corner_points[i]);
    settle();

    while (random_sent < RANDOM_ITEMS) begin
      load_random_curve();
      phase_items = $urandom_range(160, 60);
      phase_sent  = 0;
      if (holds_done == 0) begin
        // back the block up behind a stalled result side, then let it empty
        hold_request = 1'b1;
        repeat (12) begin
          offer_voltage(pick_voltage());
          phase_sent++;
          random_sent++;
        end
        drain_results();
      end
      while (phase_sent < phase_items) begin
        burst_len = $urandom_range(24, 1);
        repeat (burst_len) begin
          offer_voltage(pick_voltage());
          phase_sent++;
          random_sent++;
        end
        gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(45, 1);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        if ($urandom_range(19, 0) == 0) drain_results();
      end
      settle();
    end

    $display("%0d voltages over %0d curve settings, %0d levels checked",
             levels_sb.voltages_seen, curves_loaded, levels_sb.levels_checked);
    $display("long result hold-offs: %0d, mismatches: %0d", holds_done,
             levels_sb.errors);
    if (levels_sb.errors == 0 && levels_sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: battery_level_interpolator_unit.f
+incdir+rtl/core
rtl/core/bli_pkg.sv
rtl/core/battery_level_interpolator_unit.sv
rtl/core/bli_checker.sv
bench/battery_level_interpolator_unit_tb.sv
